### hw/rtl/assert_macros.svh
// assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// hold prop at every rising edge of clk_i
`define CUDE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define CUDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/cude_pkg.sv
package cude_pkg;

  typedef enum logic [2:0] {
    MODE_NONE,
    MODE_GA94,
    MODE_DVD,
    MODE_REPLAY,
    MODE_OTHER
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_GA_BAD_HDR  = 3'd1,
    ST_GA_TRUNC    = 3'd2,
    ST_DVD_HDR     = 3'd3,
    ST_DVD_PAIRS   = 3'd4,
    ST_DVD_PARTIAL = 3'd5,
    ST_REPLAY      = 3'd6
  } status_e;

  localparam logic [7:0] MaskLen   = 8'h1f;
  localparam logic [7:0] MaskEn    = 8'h40;
  localparam logic [7:0] MaskPairs = 8'h1e;
  localparam logic [7:0] MaskField = 8'h80;
  localparam logic [7:0] ByteFc    = 8'hfc;
  localparam logic [7:0] ByteFd    = 8'hfd;
  localparam logic [7:0] ByteFe    = 8'hfe;
  localparam logic [7:0] ByteFf    = 8'hff;
  localparam logic [7:0] ByteF8    = 8'hf8;
  localparam logic [7:0] ByteBb    = 8'hbb;
  localparam logic [7:0] Byte99    = 8'h99;

  localparam int unsigned MaxData  = 6;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrBits = $clog2(QDepth);

  typedef struct packed {
    logic [MaxData-1:0][7:0] data;
    logic [2:0]              cnt;
    logic                    stat;
    status_e                 code;
  } entry_t;

endpackage

### hw/rtl/caption_user_data_extractor_top.sv
// An accepted byte's result entry is written to the queue; its head drives the outputs.
// Throughput: one byte per cycle in while not full, one word per cycle out on pop.
// A DVD pair or ReplayTV run yields six words from one byte; a four-entry queue
// between parser and output sequencer absorbs the burst, and full rises when it fills.
// Reset: asynchronous, active low; clears parser state and empties the queue.
module caption_user_data_extractor_top
  import cude_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_packet_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       is_status_o,
  output logic [2:0] status_code_o
);

  logic   wr_en, head_valid, deq;
  entry_t wr_entry, head;

  cude_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_i         (full),
    .in_byte_i      (in_byte_i),
    .end_of_packet_i(end_of_packet_i),
    .wr_en_o        (wr_en),
    .wr_entry_o     (wr_entry)
  );

  cude_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_entry_i(wr_entry),
    .rd_en_i   (deq),
    .full_o    (full),
    .valid_o   (head_valid),
    .head_o    (head)
  );

  cude_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_i        (pop),
    .deq_o        (deq),
    .empty_o      (empty),
    .out_byte_o   (out_byte_o),
    .is_status_o  (is_status_o),
    .status_code_o(status_code_o)
  );

endmodule

### hw/rtl/cude_front.sv
`include "assert_macros.svh"

module cude_front
  import cude_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic       full_i,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_packet_i,
  output logic       wr_en_o,
  output entry_t     wr_entry_o
);

  function automatic mode_e classify(input logic [7:0] h0, input logic [7:0] h1,
                                     input logic [7:0] h2, input logic [7:0] b3);
    mode_e m;
    if (h0 == "G" && h1 == "A" && h2 == "9" && b3 == "4") begin
      m = MODE_GA94;
    end else if (h0 == "C" && h1 == "C" && h2 == 8'h01 && b3 == ByteF8) begin
      m = MODE_DVD;
    end else if ((h0 == ByteBb && h1 == 8'h02) || (h2 == Byte99 && b3 == 8'h02)) begin
      m = MODE_REPLAY;
    end else begin
      m = MODE_OTHER;
    end
    return m;
  endfunction

  logic                  accept;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d, cnt_inc, ga_off;
  mode_e                 mode_q, mode_d;
  logic [3:0][7:0]       hdr_q, hdr_d;
  logic [6:0]            ga_len_q, ga_len_d;
  logic                  ga_en_q, ga_en_d, ga_bad_q, ga_bad_d;
  logic [3:0]            dvd_total_q, dvd_total_d;
  logic [6:0]            dvd_need;
  logic                  dvd_first_q, dvd_first_d;
  logic [7:0]            pair_q [5];
  logic                  pair_we;
  logic [2:0]            pair_pos_q, pair_pos_d;
  logic                  dvd_scan_q, dvd_scan_d;
  logic [7:0]            replay6_q, replay6_d;
  entry_t                ent;

  assign accept  = push_i && !full_i;
  assign cnt_inc = (&cnt_q) ? cnt_q : cnt_q + 1'b1;
  assign ga_off  = cnt_q - COUNT_BITS'(7);

  always_comb begin
    cnt_d       = cnt_q;
    mode_d      = mode_q;
    hdr_d       = hdr_q;
    ga_len_d    = ga_len_q;
    ga_en_d     = ga_en_q;
    ga_bad_d    = ga_bad_q;
    dvd_total_d = dvd_total_q;
    dvd_first_d = dvd_first_q;
    pair_we     = 1'b0;
    pair_pos_d  = pair_pos_q;
    dvd_scan_d  = dvd_scan_q;
    replay6_d   = replay6_q;
    ent         = '0;
    ent.code    = ST_OK;
    dvd_need    = '0;
    wr_en_o     = 1'b0;
    if (accept) begin
      if (cnt_q < COUNT_BITS'(4)) begin
        hdr_d[cnt_q[1:0]] = in_byte_i;
      end
      if (cnt_q == COUNT_BITS'(3)) begin
        mode_d = classify(hdr_q[0], hdr_q[1], hdr_q[2], in_byte_i);
      end else if (cnt_q > COUNT_BITS'(3)) begin
        case (mode_q)
          MODE_GA94: begin
            if (cnt_q == COUNT_BITS'(4)) begin
              ga_bad_d = (in_byte_i != 8'h03);
            end else if (cnt_q == COUNT_BITS'(5)) begin
              ga_len_d = {2'b00, in_byte_i[4:0] & MaskLen[4:0]}
                       + {1'b0, in_byte_i[4:0] & MaskLen[4:0], 1'b0};
              ga_en_d  = |(in_byte_i & MaskEn);
            end else if (cnt_q >= COUNT_BITS'(7)) begin
              if (!ga_bad_q && ga_en_q && ga_off < COUNT_BITS'(ga_len_q)) begin
                ent.data[0] = in_byte_i;
                ent.cnt     = 3'd1;
              end
            end
          end
          MODE_DVD: begin
            if (cnt_q == COUNT_BITS'(4)) begin
              dvd_total_d = 4'((in_byte_i & MaskPairs) >> 1);
              dvd_first_d = ~|(in_byte_i & MaskField);
            end else if (dvd_scan_q) begin
              if (pair_pos_q == 3'd0 && in_byte_i != ByteFe && in_byte_i != ByteFf) begin
                dvd_scan_d = 1'b0;
              end else if (pair_pos_q < 3'd5) begin
                pair_we    = 1'b1;
                pair_pos_d = pair_pos_q + 3'd1;
              end else begin
                ent.data[0] = (pair_q[0] == ByteFf && !dvd_first_q) ? ByteFc : ByteFd;
                ent.data[1] = pair_q[1];
                ent.data[2] = pair_q[2];
                ent.data[3] = (pair_q[3] == ByteFf && dvd_first_q) ? ByteFc : ByteFd;
                ent.data[4] = pair_q[4];
                ent.data[5] = in_byte_i;
                ent.cnt     = 3'd6;
                pair_pos_d  = 3'd0;
              end
            end
          end
          MODE_REPLAY: begin
            if (cnt_q == COUNT_BITS'(6)) begin
              replay6_d = in_byte_i;
            end else if (cnt_q == COUNT_BITS'(7)) begin
              ent.data[0] = ByteFc;
              ent.data[1] = replay6_q;
              ent.data[2] = in_byte_i;
              ent.data[3] = ByteFd;
              ent.data[4] = hdr_q[2];
              ent.data[5] = hdr_q[3];
              ent.cnt     = 3'd6;
            end
          end
          default: ;
        endcase
      end
      cnt_d = cnt_inc;

      if (end_of_packet_i) begin
        ent.stat = 1'b1;
        dvd_need = {1'b0, dvd_total_d, 2'b00} + {2'b00, dvd_total_d, 1'b0};
        case (mode_d)
          MODE_GA94: begin
            if (cnt_inc < COUNT_BITS'(7) || ga_bad_d) begin
              ent.code = ST_GA_BAD_HDR;
            end else if (cnt_inc < COUNT_BITS'(7) + COUNT_BITS'(ga_len_d)) begin
              ent.code = ST_GA_TRUNC;
            end
          end
          MODE_DVD: begin
            if (cnt_inc < COUNT_BITS'(5)) begin
              ent.code = ST_DVD_HDR;
            end else if (cnt_inc < COUNT_BITS'(5) + COUNT_BITS'(dvd_need)) begin
              ent.code = ST_DVD_PAIRS;
            end else if (dvd_scan_d && pair_pos_d >= 3'd2) begin
              ent.code = ST_DVD_PARTIAL;
            end
          end
          MODE_REPLAY: begin
            if (cnt_inc < COUNT_BITS'(8)) begin
              ent.code = ST_REPLAY;
            end
          end
          default: ;
        endcase
        cnt_d       = '0;
        mode_d      = MODE_NONE;
        hdr_d       = '0;
        ga_len_d    = '0;
        ga_en_d     = 1'b0;
        ga_bad_d    = 1'b0;
        dvd_total_d = '0;
        dvd_first_d = 1'b0;
        pair_pos_d  = '0;
        dvd_scan_d  = 1'b1;
        replay6_d   = '0;
      end
      wr_en_o = (ent.cnt != 3'd0) || ent.stat;
    end
  end

  assign wr_entry_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      mode_q      <= MODE_NONE;
      hdr_q       <= '0;
      ga_len_q    <= '0;
      ga_en_q     <= 1'b0;
      ga_bad_q    <= 1'b0;
      dvd_total_q <= '0;
      dvd_first_q <= 1'b0;
      pair_pos_q  <= '0;
      dvd_scan_q  <= 1'b1;
      replay6_q   <= '0;
    end else begin
      cnt_q       <= cnt_d;
      mode_q      <= mode_d;
      hdr_q       <= hdr_d;
      ga_len_q    <= ga_len_d;
      ga_en_q     <= ga_en_d;
      ga_bad_q    <= ga_bad_d;
      dvd_total_q <= dvd_total_d;
      dvd_first_q <= dvd_first_d;
      pair_pos_q  <= pair_pos_d;
      dvd_scan_q  <= dvd_scan_d;
      replay6_q   <= replay6_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pair_we) begin
      pair_q[pair_pos_q] <= in_byte_i;
    end
  end

  `CUDE_ASSERT_NEXT(a_eop_clr, accept && end_of_packet_i, cnt_q == '0, "count not cleared")

endmodule

### hw/rtl/cude_fifo.sv
`include "assert_macros.svh"

module cude_fifo
  import cude_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_en_i,
  input  entry_t wr_entry_i,
  input  logic   rd_en_i,
  output logic   full_o,
  output logic   valid_o,
  output entry_t head_o
);

  entry_t                mem_q [QDepth];
  logic [QPtrBits-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QPtrBits:0]     count_q, count_d;
  logic                  do_wr, do_rd;

  assign full_o  = (count_q == (QPtrBits + 1)'(QDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rptr_q];
  assign do_wr   = wr_en_i && !full_o;
  assign do_rd   = rd_en_i && valid_o;

  always_comb begin
    wptr_d  = do_wr ? wptr_q + 1'b1 : wptr_q;
    rptr_d  = do_rd ? rptr_q + 1'b1 : rptr_q;
    count_d = count_q;
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_entry_i;
    end
  end

  `CUDE_ASSERT(a_count_bound, count_q <= (QPtrBits + 1)'(QDepth), "queue count over depth")

endmodule

### hw/rtl/cude_back.sv
`include "assert_macros.svh"

module cude_back
  import cude_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  entry_t     head_i,
  input  logic       pop_i,
  output logic       deq_o,
  output logic       empty_o,
  output logic [7:0] out_byte_o,
  output logic       is_status_o,
  output logic [2:0] status_code_o
);

  logic [2:0] sub_q, sub_d;
  logic       is_data, last, take;

  assign empty_o       = !head_valid_i;
  assign is_data       = (sub_q < head_i.cnt);
  assign out_byte_o    = is_data ? head_i.data[sub_q] : 8'h00;
  assign is_status_o   = !is_data;
  assign status_code_o = is_data ? ST_OK : head_i.code;
  assign last          = head_i.stat ? (sub_q == head_i.cnt) : (sub_q == head_i.cnt - 3'd1);
  assign take          = pop_i && head_valid_i;
  assign deq_o         = take && last;

  always_comb begin
    sub_d = sub_q;
    if (take) begin
      sub_d = last ? 3'd0 : sub_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= '0;
    end else begin
      sub_q <= sub_d;
    end
  end

  `CUDE_ASSERT(a_sub_in_entry, head_valid_i |-> sub_q <= head_i.cnt, "word index past entry")

endmodule

### dv/caption_user_data_extractor_top_tb.sv
module caption_user_data_extractor_top_tb
  import cude_pkg::*;
();

  localparam int unsigned CntBits = 8;
  localparam int unsigned LongLen = (1 << CntBits) + 4;
  localparam int unsigned RandBytes = 100;
  localparam int unsigned Limit = 50_000;
  localparam int unsigned IdlePct = 37;

  localparam logic [7:0] ChG = "G";
  localparam logic [7:0] ChA = "A";
  localparam logic [7:0] Ch9 = "9";
  localparam logic [7:0] Ch4 = "4";
  localparam logic [7:0] ChC = "C";
  localparam logic [7:0] GaVersion = 8'h03;
  localparam logic [7:0] DvdVersion = 8'h01;
  localparam logic [7:0] RtvTag = 8'h02;

  typedef struct packed {
    logic [7:0] data;
    logic       stat;
    status_e    code;
  } word_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eop;
    status_e    code;
  } row_t;

  localparam int unsigned NumRows = 21;
  localparam row_t Plan [NumRows] = '{
    '{8'hff, 1'b1, ST_OK},
    '{ChG, 1'b0, ST_OK}, '{ChA, 1'b0, ST_OK}, '{Ch9, 1'b0, ST_OK},
    '{Ch4, 1'b1, ST_GA_BAD_HDR},
    '{ChC, 1'b0, ST_OK}, '{ChC, 1'b0, ST_OK}, '{DvdVersion, 1'b0, ST_OK},
    '{ByteF8, 1'b1, ST_DVD_HDR},
    '{8'h00, 1'b0, ST_OK}, '{8'h00, 1'b0, ST_OK}, '{Byte99, 1'b0, ST_OK},
    '{RtvTag, 1'b1, ST_REPLAY},
    '{ChG, 1'b0, ST_OK}, '{ChA, 1'b0, ST_OK}, '{Ch9, 1'b0, ST_OK},
    '{Ch4, 1'b0, ST_OK}, '{GaVersion, 1'b0, ST_OK}, '{8'h41, 1'b0, ST_OK},
    '{8'h00, 1'b0, ST_OK}, '{8'h5a, 1'b1, ST_GA_TRUNC}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte_i = 8'h00;
  logic       end_of_packet_i = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte_o;
  logic       is_status_o;
  logic [2:0] status_code_o;

  caption_user_data_extractor_top #(
    .COUNT_BITS(CntBits)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .in_byte_i      (in_byte_i),
    .end_of_packet_i(end_of_packet_i),
    .empty          (empty),
    .pop            (pop),
    .out_byte_o     (out_byte_o),
    .is_status_o    (is_status_o),
    .status_code_o  (status_code_o)
  );

  always #5 clk_i = ~clk_i;

  // parser mirror
  logic [CntBits-1:0] pos_cnt;
  mode_e              fmt;
  logic [7:0]         hdr [4];
  logic [6:0]         ga_len;
  logic               ga_en;
  logic               ga_bad;
  logic [3:0]         dvd_pairs;
  logic               dvd_field1;
  logic [7:0]         pair_buf [6];
  logic [2:0]         pair_pos;
  logic               dvd_scan;
  logic [7:0]         rtv_b6;

  word_t       pending_words [$];
  word_t       want_w;
  logic [7:0]  pkt [$];
  bit          calm = 1'b0;
  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  int unsigned packets_sent = 0;
  int unsigned words_checked = 0;

  task automatic clear_parser();
    pos_cnt = '0;
    fmt = MODE_NONE;
    foreach (hdr[i]) hdr[i] = 8'h00;
    ga_len = '0;
    ga_en = 1'b0;
    ga_bad = 1'b0;
    dvd_pairs = '0;
    dvd_field1 = 1'b0;
    foreach (pair_buf[i]) pair_buf[i] = 8'h00;
    pair_pos = '0;
    dvd_scan = 1'b1;
    rtv_b6 = 8'h00;
  endtask

  task automatic add_word(input logic [7:0] data, input logic stat, input status_e code);
    word_t w;
    w = '{data: data, stat: stat, code: code};
    pending_words = {pending_words, w};
  endtask

  task automatic append_byte(input logic [7:0] b);
    pkt = {pkt, b};
  endtask

  function automatic mode_e detect_format(input logic [7:0] b3);
    if (hdr[0] == ChG && hdr[1] == ChA && hdr[2] == Ch9 && b3 == Ch4) return MODE_GA94;
    if (hdr[0] == ChC && hdr[1] == ChC && hdr[2] == DvdVersion && b3 == ByteF8) return MODE_DVD;
    if ((hdr[0] == ByteBb && hdr[1] == RtvTag) || (hdr[2] == Byte99 && b3 == RtvTag))
      return MODE_REPLAY;
    return MODE_OTHER;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic eop);
    int unsigned idx;
    int unsigned total;
    status_e     code;
    logic [7:0]  m;
    idx = pos_cnt;
    if (idx < 4) hdr[idx[1:0]] = b;
    if (idx == 3) begin
      fmt = detect_format(b);
    end else if (idx > 3) begin
      case (fmt)
        MODE_GA94: begin
          if (idx == 4) begin
            ga_bad = (b != GaVersion);
          end else if (idx == 5) begin
            ga_len = 7'((b & MaskLen) * 3);
            ga_en = |(b & MaskEn);
          end else if (idx >= 7 && !ga_bad && ga_en && idx - 7 < ga_len) begin
            add_word(b, 1'b0, ST_OK);
          end
        end
        MODE_DVD: begin
          if (idx == 4) begin
            dvd_pairs = 4'((b & MaskPairs) >> 1);
            dvd_field1 = !(|(b & MaskField));
          end else if (dvd_scan) begin
            if (pair_pos == 0 && b != ByteFe && b != ByteFf) begin
              dvd_scan = 1'b0;
            end else if (pair_pos < 5) begin
              pair_buf[pair_pos] = b;
              pair_pos++;
            end else begin
              pair_buf[5] = b;
              for (int f = 0; f < 2; f++) begin
                m = pair_buf[3*f];
                add_word((m == ByteFf && f == dvd_field1) ? ByteFc : ByteFd, 1'b0, ST_OK);
                add_word(pair_buf[3*f+1], 1'b0, ST_OK);
                add_word(pair_buf[3*f+2], 1'b0, ST_OK);
              end
              pair_pos = '0;
            end
          end
        end
        MODE_REPLAY: begin
          if (idx == 6) begin
            rtv_b6 = b;
          end else if (idx == 7) begin
            add_word(ByteFc, 1'b0, ST_OK);
            add_word(rtv_b6, 1'b0, ST_OK);
            add_word(b, 1'b0, ST_OK);
            add_word(ByteFd, 1'b0, ST_OK);
            add_word(hdr[2], 1'b0, ST_OK);
            add_word(hdr[3], 1'b0, ST_OK);
          end
        end
        default: ;
      endcase
    end
    if (pos_cnt != '1) pos_cnt++;
    if (eop) begin
      total = pos_cnt;
      code = ST_OK;
      case (fmt)
        MODE_GA94: begin
          if (total < 7 || ga_bad) code = ST_GA_BAD_HDR;
          else if (total - 7 < ga_len) code = ST_GA_TRUNC;
        end
        MODE_DVD: begin
          if (total < 5) code = ST_DVD_HDR;
          else if (total - 5 < dvd_pairs * 6) code = ST_DVD_PAIRS;
          else if (dvd_scan && pair_pos >= 2) code = ST_DVD_PARTIAL;
        end
        MODE_REPLAY: begin
          if (total < 8) code = ST_REPLAY;
        end
        default: ;
      endcase
      add_word(8'h00, 1'b1, code);
      clear_parser();
    end
  endtask

  // entered and left at a falling edge
  task automatic send_word(input logic [7:0] b, input logic eop, input bit fixed,
                           input status_e fixed_code);
    while (!calm && $urandom_range(99) < IdlePct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    in_byte_i <= b;
    end_of_packet_i <= eop;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    parse_byte(b, eop);
    if (fixed && eop) pending_words[pending_words.size()-1].code = fixed_code;
    bytes_sent++;
    if (eop) packets_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_packet();
    foreach (pkt[i]) send_word(pkt[i], i == pkt.size() - 1, 1'b0, ST_OK);
  endtask

  task automatic fill_to(input int n);
    while (pkt.size() < n) append_byte(8'($urandom_range(255)));
    while (pkt.size() > n) void'(pkt.pop_back());
  endtask

  task automatic build_packet();
    int         kind;
    int         n;
    int         npr;
    int         nsend;
    logic [7:0] v;
    kind = $urandom_range(9);
    if (kind <= 2) begin
      pkt = '{ChG, ChA, Ch9, Ch4};
      append_byte(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : GaVersion);
      v = 8'($urandom_range(255));
      if ($urandom_range(3) != 0) v[4:0] = 5'($urandom_range(4));
      if ($urandom_range(3) != 0) v = v | MaskEn;
      append_byte(v);
      n = 7 + 3 * int'(v[4:0]) + $urandom_range(4) - 2;
      if ($urandom_range(7) == 0) n = $urandom_range(4, 9);
      fill_to(n);
    end else if (kind <= 5) begin
      pkt = '{ChC, ChC, DvdVersion, ByteF8};
      npr = $urandom_range(3);
      if ($urandom_range(4) == 0) npr = $urandom_range(15);
      v = 8'($urandom_range(255));
      v[4:1] = 4'(npr);
      append_byte(v);
      nsend = npr + $urandom_range(2) - 1;
      for (int k = 0; k < nsend; k++) begin
        append_byte($urandom_range(1) ? ByteFf : ByteFe);
        append_byte(8'($urandom_range(255)));
        append_byte(8'($urandom_range(255)));
        case ($urandom_range(2))
          0: append_byte(ByteFf);
          1: append_byte(ByteFe);
          default: append_byte(8'($urandom_range(255)));
        endcase
        append_byte(8'($urandom_range(255)));
        append_byte(8'($urandom_range(255)));
      end
      case ($urandom_range(3))
        0: ;
        1: begin
          append_byte(8'($urandom_range(253)));
          fill_to(pkt.size() + $urandom_range(3));
        end
        2: begin
          append_byte($urandom_range(1) ? ByteFf : ByteFe);
          fill_to(pkt.size() + $urandom_range(4));
        end
        default: fill_to(pkt.size() + $urandom_range(5));
      endcase
      if ($urandom_range(11) == 0) fill_to($urandom_range(1, pkt.size()));
    end else if (kind <= 7) begin
      if ($urandom_range(1)) begin
        pkt = '{ByteBb, RtvTag, 8'($urandom_range(255)), 8'($urandom_range(255))};
      end else begin
        pkt = '{8'($urandom_range(255)), 8'($urandom_range(255)), Byte99, RtvTag};
      end
      fill_to(($urandom_range(3) == 0) ? $urandom_range(4, 12) : 8);
    end else if (kind == 8) begin
      pkt.delete();
      fill_to($urandom_range(4, 12));
    end else begin
      pkt.delete();
      fill_to($urandom_range(1, 3));
    end
  endtask

  always @(negedge clk_i) begin
    pop <= rst_ni && (calm || $urandom_range(99) >= IdlePct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      words_checked++;
      if (pending_words.size() == 0) begin
        $display("%0t ERROR unexpected word: out_byte %02h is_status %0b status_code %0d",
                 $time, out_byte_o, is_status_o, status_code_o);
        errors++;
      end else begin
        want_w = pending_words.pop_front();
        if (out_byte_o !== want_w.data) begin
          $display("%0t ERROR out_byte_o: expected %02h, got %02h",
                   $time, want_w.data, out_byte_o);
          errors++;
        end
        if (is_status_o !== want_w.stat) begin
          $display("%0t ERROR is_status_o: expected %0b, got %0b",
                   $time, want_w.stat, is_status_o);
          errors++;
        end
        if (status_code_o !== 3'(want_w.code)) begin
          $display("%0t ERROR status_code_o: expected %0d, got %0d",
                   $time, want_w.code, status_code_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == Limit) begin
      $display("%0t timeout with %0d words outstanding", $time, pending_words.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    clear_parser();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumRows; i++) send_word(Plan[i].b, Plan[i].eop, 1'b1, Plan[i].code);

    while (bytes_sent < NumRows + RandBytes) begin
      build_packet();
      send_packet();
    end

    // run the byte counter into saturation with no idling on either side
    calm = 1'b1;
    pkt = '{ChG, ChA, Ch9, Ch4, GaVersion, MaskEn | MaskLen, 8'h00};
    fill_to(LongLen);
    send_packet();
    push <= 1'b0;
    calm = 1'b0;

    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d bytes in %0d packets (GA94, DVD, ReplayTV, other, short),", bytes_sent,
             packets_sent);
    $display("including one packet past counter saturation; %0d words checked.", words_checked);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
